// ===== rtl/ffc_pkg.sv =====
// Shared types, constants and constant tables for the feed-forward compressor.
package ffc_pkg;

  localparam int unsigned SampleBits    = 16;
  localparam int unsigned CoeffFracBits = 24;
  localparam int unsigned EnvWidth      = 25;
  localparam int unsigned EnvFracBits   = EnvWidth - SampleBits;

  // Configuration register indexes.
  localparam logic [7:0] RegThreshold = 8'd0;
  localparam logic [7:0] RegSlope     = 8'd1;
  localparam logic [7:0] RegAttack    = 8'd2;
  localparam logic [7:0] RegRelease   = 8'd3;

  localparam logic [14:0] ThresholdReset = 15'd3277;
  localparam logic [15:0] SlopeReset     = 16'd49152;
  localparam logic [23:0] AttackReset    = 24'd16707456;
  localparam logic [23:0] ReleaseReset   = 24'd16773721;

  localparam logic [16:0] UnityGain = 17'h10000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ENV_A,
    S_ENV_B,
    S_CMP,
    S_LOG_E,
    S_LOG_T,
    S_SLOPE,
    S_EXP,
    S_ROUND,
    S_OUT
  } ffc_state_e;

  typedef logic [15:0][29:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bt;
    logic [63:0] vv;
    root = '0;
    bt   = 64'd1 << 62;
    vv   = v;
    for (int i = 0; i < 32; i++) begin
      if (bt > vv) begin
        bt = bt >> 2;
      end
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (vv >= root + bt) begin
          vv   = vv - (root + bt);
          root = (root >> 1) + bt;
        end else begin
          root = root >> 1;
        end
        bt = bt >> 2;
      end
    end
    return root;
  endfunction

  // Entry b holds 2^(-2^(b-16)) in Q1.30, the factor for fraction bit b of the exponent.
  function automatic root_tab_t gen_roots();
    root_tab_t   tab;
    logic [63:0] r;
    r = 64'd1 << 29;
    for (int b = 15; b >= 0; b--) begin
      r      = isqrt64(r << 30);
      tab[b] = r[29:0];
    end
    return tab;
  endfunction

  localparam root_tab_t RootTab = gen_roots();

  function automatic logic [4:0] msb_pos(input logic [24:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 25; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

// ===== rtl/ffc_mul.sv =====
// Shared 32 x 32 unsigned multiplier used for every product the sequencer forms.
module ffc_mul (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  assign p_o = 64'(a_i) * 64'(b_i);

endmodule

// ===== rtl/feedforward_compressor_top.sv =====
// Feed-forward compressor: config registers, sequencer and datapath around one multiplier.
//
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid_i/in_stall_o | in_sample_i, start_of_buffer_i
//  out     | source    | out_valid_o/out_stall_i | out_sample_o, gain_applied_o, compressing_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// An item below the threshold takes the two envelope products and the output product;
// above it, the one shared multiplier also works in turn through 16 squarings for
// each of two logarithms, one slope product and 16 exponent products.
// Reset clears the envelope, the sequencer and the output valid, and loads defaults.
// in_stall_o is high while an item is in work; a waiting result is held in the
// output register, and the last step waits while that result is valid and out_stall_i is high.
module feedforward_compressor_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   in_sample_i,
  input  logic                 start_of_buffer_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   out_sample_o,
  output logic [16:0]          gain_applied_o,
  output logic                 compressing_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [7:0]           cfg_index_i,
  input  logic [23:0]          cfg_data_i
);
  import ffc_pkg::*;

  ffc_state_e state_q, state_d;

  logic [14:0] thr_q;
  logic [15:0] slope_q;
  logic [23:0] attack_q, release_q;

  logic [24:0] env_q, env_d;
  logic [23:0] c_q, c_d;
  logic [15:0] mag_q, mag_d;
  logic        neg_q, neg_d;
  logic [49:0] sum_q, sum_d;
  logic [30:0] m_q, m_d;
  logic [20:0] res_q, res_d;
  logic [20:0] le_q, le_d;
  logic [20:0] d_q, d_d;
  logic [20:0] e_q, e_d;
  logic [30:0] pacc_q, pacc_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [16:0] gain_q, gain_d;
  logic        comp_q, comp_d;

  logic               out_valid_q;
  logic signed [15:0] out_sample_q;
  logic [16:0]        out_gain_q;
  logic               out_comp_q;
  logic signed [15:0] y_sat;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic        in_accept;
  logic        out_free;
  logic        out_load;
  logic [23:0] thr_ext;
  logic        comp_now;

  ffc_mul u_mul (
    .a_i(mul_a),
    .b_i(mul_b),
    .p_o(mul_p)
  );

  assign thr_ext   = {thr_q, 9'b0};
  assign comp_now  = env_q > {1'b0, thr_ext};
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_accept = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_ENV_A;
      S_ENV_A: state_d = S_ENV_B;
      S_ENV_B: state_d = S_CMP;
      S_CMP:   state_d = comp_now ? S_LOG_E : S_OUT;
      S_LOG_E: if (cnt_q == 4'd0) state_d = S_LOG_T;
      S_LOG_T: if (cnt_q == 4'd0) state_d = S_SLOPE;
      S_SLOPE: state_d = S_EXP;
      S_EXP:   if (cnt_q == 4'd0) state_d = S_ROUND;
      S_ROUND: state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE:  in_stall_o = 1'b0;
      S_OUT:   out_load = out_free;
      default: ;
    endcase
  end

  // Datapath: operand selection for the shared multiplier and register updates.
  always_comb begin
    logic [24:0] one_minus;
    logic [49:0] tsum;
    logic [31:0] sq;
    logic [4:0]  p;
    logic [24:0] tv;
    logic [5:0]  sh;
    logic [31:0] rsum;
    logic [33:0] ps;
    logic [33:0] yr;
    logic signed [17:0] ysh;

    env_d  = env_q;
    c_d    = c_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    sum_d  = sum_q;
    m_d    = m_q;
    res_d  = res_q;
    le_d   = le_q;
    d_d    = d_q;
    e_d    = e_q;
    pacc_d = pacc_q;
    cnt_d  = cnt_q;
    gain_d = gain_q;
    comp_d = comp_q;
    mul_a  = '0;
    mul_b  = '0;
    one_minus = '0;
    tsum   = '0;
    sq     = '0;
    p      = '0;
    tv     = '0;
    sh     = '0;
    rsum   = '0;
    ps     = '0;
    yr     = '0;
    ysh    = '0;
    y_sat  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          neg_d = in_sample_i[15];
          mag_d = in_sample_i[15] ? (~in_sample_i + 16'd1) : in_sample_i;
          env_d = start_of_buffer_i ? '0 : env_q;
          c_d   = ({mag_d, 9'b0} > env_d) ? attack_q : release_q;
        end
      end
      S_ENV_A: begin
        mul_a = {8'b0, c_q};
        mul_b = {7'b0, env_q};
        sum_d = mul_p[49:0];
      end
      S_ENV_B: begin
        one_minus = (25'd1 << CoeffFracBits) - {1'b0, c_q};
        mul_a = {7'b0, one_minus};
        mul_b = {7'b0, mag_q, 9'b0};
        tsum  = sum_q + mul_p[49:0] + (50'd1 << (CoeffFracBits - 1));
        env_d = tsum[48:24];
      end
      S_CMP: begin
        comp_d = comp_now;
        gain_d = UnityGain;
        p      = msb_pos(env_q);
        m_d    = 31'({6'b0, env_q} << (5'd30 - p));
        res_d  = {p, 16'b0};
        cnt_d  = 4'd15;
      end
      S_LOG_E, S_LOG_T: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
        sq    = mul_p[61:30];
        if (sq[31]) begin
          res_d[cnt_q] = 1'b1;
          m_d = sq[31:1];
        end else begin
          m_d = sq[30:0];
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          if (state_q == S_LOG_E) begin
            le_d  = res_d;
            // A zero threshold is taken as one envelope step.
            tv    = (thr_ext == '0) ? 25'd1 : {1'b0, thr_ext};
            p     = msb_pos(tv);
            m_d   = 31'({6'b0, tv} << (5'd30 - p));
            res_d = {p, 16'b0};
            cnt_d = 4'd15;
          end else begin
            d_d = (le_q > res_d) ? (le_q - res_d) : '0;
          end
        end
      end
      S_SLOPE: begin
        mul_a  = {11'b0, d_q};
        mul_b  = {16'b0, slope_q};
        e_d    = mul_p[36:16];
        pacc_d = 31'h4000_0000;
        cnt_d  = 4'd15;
      end
      S_EXP: begin
        mul_a = {1'b0, pacc_q};
        mul_b = {2'b0, RootTab[cnt_q]};
        if (e_q[cnt_q]) begin
          pacc_d = mul_p[60:30];
        end
        cnt_d = cnt_q - 4'd1;
      end
      S_ROUND: begin
        sh = {1'b0, e_q[20:16]} + 6'd14;
        // With the shift at 32 or more the Q1.30 product rounds to zero.
        if (sh >= 6'd32) begin
          gain_d = '0;
        end else begin
          rsum   = {1'b0, pacc_q} + (32'd1 << (sh - 6'd1));
          gain_d = 17'(rsum >> sh);
        end
      end
      S_OUT: begin
        mul_a = {16'b0, mag_q};
        mul_b = {15'b0, gain_q};
        ps    = neg_q ? (34'd0 - {1'b0, mul_p[32:0]}) : {1'b0, mul_p[32:0]};
        yr    = ps + 34'd32768;
        ysh   = $signed(yr[33:16]);
        if (ysh > 18'sd32767) begin
          y_sat = 16'sh7FFF;
        end else if (ysh < -18'sd32768) begin
          y_sat = -16'sh8000;
        end else begin
          y_sat = ysh[15:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      env_q     <= '0;
      thr_q     <= ThresholdReset;
      slope_q   <= SlopeReset;
      attack_q  <= AttackReset;
      release_q <= ReleaseReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      env_q   <= env_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          RegThreshold: thr_q     <= cfg_data_i[14:0];
          RegSlope:     slope_q   <= cfg_data_i[15:0];
          RegAttack:    attack_q  <= cfg_data_i;
          RegRelease:   release_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q    <= c_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    sum_q  <= sum_d;
    m_q    <= m_d;
    res_q  <= res_d;
    le_q   <= le_d;
    d_q    <= d_d;
    e_q    <= e_d;
    pacc_q <= pacc_d;
    cnt_q  <= cnt_d;
    gain_q <= gain_d;
    comp_q <= comp_d;
    if (out_load) begin
      out_sample_q <= y_sat;
      out_gain_q   <= gain_q;
      out_comp_q   <= comp_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = out_sample_q;
  assign gain_applied_o = out_gain_q;
  assign compressing_o  = out_comp_q;

`ifndef SYNTHESIS
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q == S_ENV_A)
    else $error("accepted request did not start the envelope update");
  a_unity_gain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !compressing_o) |-> gain_applied_o == UnityGain)
    else $error("gain not unity while below threshold");
  a_gain_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> gain_applied_o <= UnityGain)
    else $error("gain above unity");
  a_env_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    env_q <= 25'h100_0000)
    else $error("envelope above full scale");
`endif

endmodule
